[src/dma_channel_register_block_assert.svh]
// Assertion macros for the DMA channel register block
`ifndef DMA_CHANNEL_REGISTER_BLOCK_ASSERT_SVH
`define DMA_CHANNEL_REGISTER_BLOCK_ASSERT_SVH
`ifndef ASSERT_OFF
`define DCRB_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define DCRB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define DCRB_ASSERT_NOW(label, pre, post, msg)
`define DCRB_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[src/dcrb_pkg.sv]
// Types, constants and helpers of the DMA channel register block
package dcrb_pkg;

  localparam int CH_IDX_W = 4;

  localparam logic [1:0] FLD_CTRL  = 2'd0;
  localparam logic [1:0] FLD_READ  = 2'd1;
  localparam logic [1:0] FLD_WRITE = 2'd2;
  localparam logic [1:0] FLD_COUNT = 2'd3;

  localparam logic [31:0] CT_EN     = 32'h0000_0001;
  localparam logic [31:0] CT_INCR_RD = 32'h0000_0010;
  localparam logic [31:0] CT_INCR_WR = 32'h0000_0020;
  localparam logic [31:0] CT_QUIET  = 32'h0020_0000;
  localparam logic [31:0] CT_BUSY   = 32'h0100_0000;
  localparam logic [31:0] CT_WERR   = 32'h2000_0000;
  localparam logic [31:0] CT_RERR   = 32'h4000_0000;
  localparam logic [31:0] CT_AHBERR = 32'h8000_0000;
  localparam int          CT_CHAIN_LSB = 11;

  localparam logic [11:0] OFF_INTR   = 12'h400;
  localparam logic [11:0] OFF_INTE0  = 12'h404;
  localparam logic [11:0] OFF_INTF0  = 12'h408;
  localparam logic [11:0] OFF_INTS0  = 12'h40C;
  localparam logic [11:0] OFF_INTE1  = 12'h414;
  localparam logic [11:0] OFF_INTF1  = 12'h418;
  localparam logic [11:0] OFF_INTS1  = 12'h41C;
  localparam logic [11:0] OFF_TIMER0 = 12'h420;
  localparam logic [11:0] OFF_TIMER1 = 12'h424;
  localparam logic [11:0] OFF_TIMER2 = 12'h428;
  localparam logic [11:0] OFF_TIMER3 = 12'h42C;
  localparam logic [11:0] OFF_MULTI  = 12'h430;
  localparam logic [11:0] OFF_SNIFFC = 12'h434;
  localparam logic [11:0] OFF_SNIFFD = 12'h438;
  localparam logic [11:0] OFF_ABORT  = 12'h444;
  localparam logic [11:0] OFF_NCHAN  = 12'h448;

  typedef struct packed {
    logic [31:0] ctrl;
    logic [31:0] raddr;
    logic [31:0] waddr;
    logic [31:0] count;
  } chan_row_t;

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [CH_IDX_W-1:0] idx;
    chan_row_t           wdata;
  } mem_req_t;

  function automatic logic [1:0] fld_sel(input logic [1:0] alias_sel, input logic [1:0] word);
    logic [1:0] f;
    case (alias_sel)
      2'd0: begin
        case (word)
          2'd0: f = FLD_READ;
          2'd1: f = FLD_WRITE;
          2'd2: f = FLD_COUNT;
          default: f = FLD_CTRL;
        endcase
      end
      2'd1: begin
        case (word)
          2'd0: f = FLD_CTRL;
          2'd1: f = FLD_READ;
          2'd2: f = FLD_WRITE;
          default: f = FLD_COUNT;
        endcase
      end
      2'd2: begin
        case (word)
          2'd0: f = FLD_CTRL;
          2'd1: f = FLD_COUNT;
          2'd2: f = FLD_READ;
          default: f = FLD_WRITE;
        endcase
      end
      default: begin
        case (word)
          2'd0: f = FLD_CTRL;
          2'd1: f = FLD_WRITE;
          2'd2: f = FLD_COUNT;
          default: f = FLD_READ;
        endcase
      end
    endcase
    return f;
  endfunction

endpackage

[src/dcrb_chan_mem.sv]
// Channel register memory with per-channel valid bits and reset-value substitution
module dcrb_chan_mem
  import dcrb_pkg::*;
#(
  parameter int NUM_CHANNELS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mem_req_t  req,
  output chan_row_t rdata
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  chan_row_t               mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  chan_row_t               rdata_r;
  logic                    rvld_r;
  logic [CH_IDX_W-1:0]     ridx_r;
  chan_row_t               rst_row;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.idx[CW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.idx[CW-1:0]];
      ridx_r  <= req.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.idx[CW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.idx[CW-1:0]];
      end
    end
  end

  always_comb begin
    rst_row      = '0;
    rst_row.ctrl = 32'(ridx_r) << CT_CHAIN_LSB;
    rdata        = rvld_r ? rdata_r : rst_row;
  end

endmodule

[src/dma_channel_register_block.sv]
// Top level of the DMA channel register block: access sequencer and global registers
// A new access is accepted only when the previous one has completed (sequencer idle).
// A trigger visits each channel of its chain; a multi-channel trigger scans one channel
// per cycle while no chain runs; an abort reads and rewrites each set channel.
// A full output stalls the sequencer when it emits a command or a completion.
// Reset (rst_n, synchronous): registers cleared, channels chain to themselves.
`include "dma_channel_register_block_assert.svh"
module dma_channel_register_block
  import dcrb_pkg::*;
#(
  parameter int NUM_CHANNELS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // offset[11:0], wdata[43:12], zero pad
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // read_data, src_addr, dst_addr, beat_count,
                                   // beat_size, rd_incr, wr_incr, irq0, irq1, pad
  output logic         out_tuser,  // result_kind
  output logic         out_tlast   // last
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NW = $clog2(NUM_CHANNELS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_AMOD   = 4'd2;
  localparam logic [3:0] S_CRD    = 4'd3;
  localparam logic [3:0] S_CEX    = 4'd4;
  localparam logic [3:0] S_RET    = 4'd5;
  localparam logic [3:0] S_MSCAN  = 4'd6;
  localparam logic [3:0] S_ABSCAN = 4'd7;
  localparam logic [3:0] S_ABWR   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]              state_r, state_nxt;
  logic                    kind_r;
  logic [11:0]             off_r;
  logic [31:0]             wdata_r;
  logic [31:0]             rd_r, rd_nxt;
  logic                    multi_r, multi_nxt;
  logic [NUM_CHANNELS-1:0] scan_r, scan_nxt;
  logic [NW-1:0]           idx_r, idx_nxt;
  logic [NW-1:0]           steps_r, steps_nxt;
  logic [CH_IDX_W-1:0]     cur_r, cur_nxt;

  logic [NUM_CHANNELS-1:0] irq_raw_r, irq_raw_nxt;
  logic [NUM_CHANNELS-1:0] inte0_r, intf0_r, inte1_r, intf1_r;
  logic [31:0]             timer_r [4];
  logic [31:0]             sniffc_r, sniffd_r;

  logic                    out_tvalid_r;
  logic [135:0]            out_tdata_r;
  logic                    out_tuser_r, out_tlast_r;
  logic                    emit_cmd, emit_done, out_free;
  logic [135:0]            cmd_data;

  mem_req_t                req;
  chan_row_t               row;
  chan_row_t               row_mod;

  logic                    is_chan;
  logic [CH_IDX_W-1:0]     off_ch;
  logic [1:0]              word;
  logic [1:0]              fld;
  logic [31:0]             glob_rd;
  logic [1:0]              bsize;
  logic [31:0]             span;
  logic [CH_IDX_W-1:0]     chain_nxt;
  logic                    chain_stop;
  logic                    run_ok;
  logic [31:0]             keep;
  logic                    glob_wr;

  dcrb_chan_mem #(.NUM_CHANNELS(NUM_CHANNELS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (row)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign is_chan = (off_r < 12'(NUM_CHANNELS * 64));
  assign off_ch  = off_r[9:6];
  assign word    = off_r[3:2];
  assign fld     = fld_sel(off_r[5:4], word);
  assign keep    = CT_BUSY | CT_AHBERR | CT_WERR | CT_RERR;

  assign bsize      = (row.ctrl[3:2] == 2'd3) ? 2'd2 : row.ctrl[3:2];
  assign span       = row.count << bsize;
  assign chain_nxt  = row.ctrl[CT_CHAIN_LSB +: CH_IDX_W];
  assign chain_stop = (chain_nxt == cur_r) || (5'(chain_nxt) >= 5'(NUM_CHANNELS)) ||
                      (steps_r == NW'(NUM_CHANNELS - 1));
  assign run_ok     = ((row.ctrl & CT_EN) != '0) && (row.count != '0);

  assign cmd_data = {2'b00,
                     ((row.ctrl & CT_QUIET) == '0) && inte1_r[cur_r[CW-1:0]],
                     ((row.ctrl & CT_QUIET) == '0) && inte0_r[cur_r[CW-1:0]],
                     (row.ctrl & CT_INCR_WR) != '0,
                     (row.ctrl & CT_INCR_RD) != '0,
                     bsize, row.count, row.waddr, row.raddr, 32'h0};

  always_comb begin
    case (off_r)
      OFF_INTR:   glob_rd = 32'(irq_raw_r);
      OFF_INTE0:  glob_rd = 32'(inte0_r);
      OFF_INTF0:  glob_rd = 32'(intf0_r);
      OFF_INTS0:  glob_rd = 32'((irq_raw_r | intf0_r) & inte0_r);
      OFF_INTE1:  glob_rd = 32'(inte1_r);
      OFF_INTF1:  glob_rd = 32'(intf1_r);
      OFF_INTS1:  glob_rd = 32'((irq_raw_r | intf1_r) & inte1_r);
      OFF_TIMER0: glob_rd = timer_r[0];
      OFF_TIMER1: glob_rd = timer_r[1];
      OFF_TIMER2: glob_rd = timer_r[2];
      OFF_TIMER3: glob_rd = timer_r[3];
      OFF_SNIFFC: glob_rd = sniffc_r;
      OFF_SNIFFD: glob_rd = sniffd_r;
      OFF_NCHAN:  glob_rd = 32'(NUM_CHANNELS);
      default:    glob_rd = 32'h0;
    endcase
  end

  always_comb begin
    row_mod = row;
    case (fld)
      FLD_CTRL:  row_mod.ctrl = ((row.ctrl & keep) & ~(wdata_r & (CT_WERR | CT_RERR))) |
                                (wdata_r & ~keep);
      FLD_READ:  row_mod.raddr = wdata_r;
      FLD_WRITE: row_mod.waddr = wdata_r;
      default:   row_mod.count = wdata_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    rd_nxt      = rd_r;
    multi_nxt   = multi_r;
    scan_nxt    = scan_r;
    idx_nxt     = idx_r;
    steps_nxt   = steps_r;
    cur_nxt     = cur_r;
    irq_raw_nxt = irq_raw_r;
    req         = '0;
    emit_cmd    = 1'b0;
    emit_done   = 1'b0;
    glob_wr     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DEC;
          rd_nxt    = 32'h0;
        end
      end
      S_DEC: begin
        if (is_chan) begin
          req.rd_en = 1'b1;
          req.idx   = off_ch;
          state_nxt = S_AMOD;
        end else if (!kind_r) begin
          rd_nxt    = glob_rd;
          state_nxt = S_DONE;
        end else if (off_r == OFF_MULTI) begin
          scan_nxt  = wdata_r[NUM_CHANNELS-1:0];
          idx_nxt   = '0;
          multi_nxt = 1'b1;
          state_nxt = S_MSCAN;
        end else if (off_r == OFF_ABORT) begin
          scan_nxt  = wdata_r[NUM_CHANNELS-1:0];
          idx_nxt   = '0;
          state_nxt = S_ABSCAN;
        end else begin
          glob_wr = 1'b1;
          if (off_r == OFF_INTR) begin
            irq_raw_nxt = irq_raw_r & ~wdata_r[NUM_CHANNELS-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_AMOD: begin
        if (!kind_r) begin
          case (fld)
            FLD_CTRL:  rd_nxt = row.ctrl;
            FLD_READ:  rd_nxt = row.raddr;
            FLD_WRITE: rd_nxt = row.waddr;
            default:   rd_nxt = row.count;
          endcase
          state_nxt = S_DONE;
        end else begin
          req.wr_en = 1'b1;
          req.idx   = off_ch;
          req.wdata = row_mod;
          multi_nxt = 1'b0;
          if (word == 2'd3) begin
            cur_nxt   = off_ch;
            steps_nxt = '0;
            state_nxt = S_CRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CRD: begin
        req.rd_en = 1'b1;
        req.idx   = cur_r;
        state_nxt = S_CEX;
      end
      S_CEX: begin
        if (!run_ok) begin
          state_nxt = S_RET;
        end else if (out_free) begin
          emit_cmd  = 1'b1;
          req.wr_en = 1'b1;
          req.idx   = cur_r;
          req.wdata = row;
          if ((row.ctrl & CT_INCR_RD) != '0) req.wdata.raddr = row.raddr + span;
          if ((row.ctrl & CT_INCR_WR) != '0) req.wdata.waddr = row.waddr + span;
          req.wdata.count = '0;
          if ((row.ctrl & CT_QUIET) == '0) begin
            irq_raw_nxt[cur_r[CW-1:0]] = 1'b1;
          end
          if (chain_stop) begin
            state_nxt = S_RET;
          end else begin
            cur_nxt   = chain_nxt;
            steps_nxt = steps_r + 1'b1;
            state_nxt = S_CRD;
          end
        end
      end
      S_RET: begin
        state_nxt = multi_r ? S_MSCAN : S_DONE;
      end
      S_MSCAN: begin
        if (idx_r == NW'(NUM_CHANNELS)) begin
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r >> 1;
          idx_nxt  = idx_r + 1'b1;
          if (scan_r[0]) begin
            cur_nxt   = CH_IDX_W'(idx_r);
            steps_nxt = '0;
            state_nxt = S_CRD;
          end
        end
      end
      S_ABSCAN: begin
        if (idx_r == NW'(NUM_CHANNELS)) begin
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r >> 1;
          idx_nxt  = idx_r + 1'b1;
          if (scan_r[0]) begin
            req.rd_en = 1'b1;
            req.idx   = CH_IDX_W'(idx_r);
            cur_nxt   = CH_IDX_W'(idx_r);
            state_nxt = S_ABWR;
          end
        end
      end
      S_ABWR: begin
        req.wr_en       = 1'b1;
        req.idx         = cur_r;
        req.wdata       = row;
        req.wdata.count = '0;
        state_nxt       = S_ABSCAN;
      end
      S_DONE: begin
        if (out_free) begin
          emit_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      multi_r      <= 1'b0;
      irq_raw_r    <= '0;
      inte0_r      <= '0;
      intf0_r      <= '0;
      inte1_r      <= '0;
      intf1_r      <= '0;
      timer_r[0]   <= '0;
      timer_r[1]   <= '0;
      timer_r[2]   <= '0;
      timer_r[3]   <= '0;
      sniffc_r     <= '0;
      sniffd_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      multi_r   <= multi_nxt;
      irq_raw_r <= irq_raw_nxt;
      if (glob_wr) begin
        case (off_r)
          OFF_INTE0:  inte0_r    <= wdata_r[NUM_CHANNELS-1:0];
          OFF_INTF0:  intf0_r    <= wdata_r[NUM_CHANNELS-1:0];
          OFF_INTE1:  inte1_r    <= wdata_r[NUM_CHANNELS-1:0];
          OFF_INTF1:  intf1_r    <= wdata_r[NUM_CHANNELS-1:0];
          OFF_TIMER0: timer_r[0] <= wdata_r;
          OFF_TIMER1: timer_r[1] <= wdata_r;
          OFF_TIMER2: timer_r[2] <= wdata_r;
          OFF_TIMER3: timer_r[3] <= wdata_r;
          OFF_SNIFFC: sniffc_r   <= wdata_r;
          OFF_SNIFFD: sniffd_r   <= wdata_r;
          default: ;
        endcase
      end
      if (emit_cmd || emit_done) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      kind_r  <= in_tuser;
      off_r   <= in_tdata[11:0];
      wdata_r <= in_tdata[43:12];
    end
    rd_r    <= rd_nxt;
    scan_r  <= scan_nxt;
    idx_r   <= idx_nxt;
    steps_r <= steps_nxt;
    cur_r   <= cur_nxt;
    if (emit_cmd) begin
      out_tdata_r <= cmd_data;
      out_tuser_r <= 1'b1;
      out_tlast_r <= 1'b0;
    end else if (emit_done) begin
      out_tdata_r <= {104'h0, rd_r};
      out_tuser_r <= 1'b0;
      out_tlast_r <= 1'b1;
    end
  end

  `DCRB_ASSERT_NOW(a_mem_one_port, req.rd_en, !req.wr_en, "channel memory read and write collide")
  `DCRB_ASSERT_NOW(a_chain_bound, state_r == S_CEX, steps_r < NW'(NUM_CHANNELS), "chain exceeds channel count")
  `DCRB_ASSERT_NEXT(a_done_last, emit_done, out_tvalid && out_tlast && !out_tuser && state_r == S_IDLE, "completion not presented")
  `DCRB_ASSERT_NEXT(a_cmd_not_last, emit_cmd, out_tvalid && out_tuser && !out_tlast, "command marked last")

endmodule
